/* sv/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg: shared types for the positional array list
// Word formats for the command and result channels, operation codes and
// the control group that the list core broadcasts to every cell.
// ----------------------------------------------------------------------------
package pal_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_READ    = 2'd2,
		OP_REPLACE = 2'd3
	} pal_op_t;

	// command word
	typedef struct packed {
		pal_op_t            opcode;
		logic [4:0]         position;
		logic signed [31:0] value;
	} pal_cmd_t;

	// result word
	typedef struct packed {
		logic               ok;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic               is_full;
	} pal_res_t;

	// control broadcast to the cells
	typedef struct packed {
		pal_op_t op;
		logic    apply;
	} pal_ctrl_t;

endpackage

/* sv/pal_cell.sv */
// ----------------------------------------------------------------------------
// pal_cell: one slot of the positional array list
// Holds one entry and decides from the broadcast command whether to load
// the new word, take its left neighbor (insert shift) or its right
// neighbor (remove shift), or hold.
// ----------------------------------------------------------------------------
module pal_cell #(
	parameter int IDX = 0,
	parameter int PW  = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pal_pkg::pal_ctrl_t  ctrl,
	input  logic [PW-1:0]       pos_idx,
	input  logic [PW-1:0]       used,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  left_data,
	input  logic signed [31:0]  right_data,
	output logic signed [31:0]  data,
	output logic                hit
);
	import pal_pkg::*;

	localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
	localparam logic [PW-1:0] MY_NEXT = PW'(IDX + 1);

	logic signed [31:0] slot_q;
	logic signed [31:0] slot_d;

	assign hit = (MY_IDX == pos_idx);

	// next slot contents
	always_comb begin
		slot_d = slot_q;
		unique case (ctrl.op)
			OP_INSERT: begin
				if (hit) begin
					slot_d = value;
				end else if (MY_IDX > pos_idx && MY_IDX <= used) begin
					slot_d = left_data;
				end
			end
			OP_REMOVE: begin
				if (MY_IDX >= pos_idx && MY_NEXT < used) begin
					slot_d = right_data;
				end
			end
			OP_REPLACE: begin
				if (hit) begin
					slot_d = value;
				end
			end
			OP_READ: begin
				slot_d = slot_q;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	// slot register, written only by an accepted operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.apply) begin
			slot_q <= slot_d;
		end
	end

	assign data = slot_q;

endmodule

/* sv/positional_array_list.sv */
// ----------------------------------------------------------------------------
// positional_array_list: fixed-capacity ordered list addressed by position
// Row of slot cells with insert, remove, read and replace at a 1-based
// position, one result word per command word.
// ----------------------------------------------------------------------------
// On each accepted command word the row of CAPACITY cells shifts
// all entries in parallel, and the read word is gathered from the cell
// whose index matches the position. A new command is taken every cycle as
// long as the result register is empty or being drained in the same cycle.
// Rejected commands (bad position, full or empty list) return ok low and
// leave the list as it was. Reset clears every slot and the count at once.
// ----------------------------------------------------------------------------
module positional_array_list #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  pal_pkg::pal_cmd_t  cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output pal_pkg::pal_res_t  res
);
	import pal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;
	localparam logic [PW-1:0] CAP = PW'(CAPACITY);

	logic [CW-1:0]      used_q;
	logic               res_valid_q;
	pal_res_t           res_q;

	logic               accept;
	logic [PW-1:0]      pos_ext;
	logic [PW-1:0]      used_ext;
	logic [PW-1:0]      pos_idx;
	logic [PW-1:0]      used_new;
	logic               ok;
	logic signed [31:0] rd_gather;
	pal_ctrl_t          ctrl;
	pal_res_t           res_d;

	logic signed [31:0] cell_data [CAPACITY];
	logic               cell_hit  [CAPACITY];

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	assign pos_ext  = PW'(cmd.position);
	assign used_ext = PW'(used_q);
	assign pos_idx  = pos_ext - PW'(1);

	// position check
	always_comb begin
		if (cmd.opcode == OP_INSERT) begin
			ok = (pos_ext != '0) && (pos_ext <= used_ext + PW'(1)) && (used_ext < CAP);
		end else begin
			ok = (pos_ext != '0) && (pos_ext <= used_ext);
		end
	end

	assign ctrl.op    = cmd.opcode;
	assign ctrl.apply = accept && ok;

	// row of slot cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		pal_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.pos_idx    (pos_idx),
			.used       (used_ext),
			.value      (cmd.value),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.hit        (cell_hit[i])
		);
	end

	// gather the addressed entry
	always_comb begin
		rd_gather = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_hit[i]) begin
				rd_gather = rd_gather | cell_data[i];
			end
		end
	end

	// count after the operation
	always_comb begin
		used_new = used_ext;
		if (ok) begin
			unique case (cmd.opcode)
				OP_INSERT: used_new = used_ext + PW'(1);
				OP_REMOVE: used_new = used_ext - PW'(1);
				default:   used_new = used_ext;
			endcase
		end
	end

	// result word
	always_comb begin
		res_d.ok          = ok;
		res_d.read_value  = (ok && (cmd.opcode == OP_REMOVE || cmd.opcode == OP_READ))
			? rd_gather : '0;
		res_d.entry_count = used_new[4:0];
		res_d.is_empty    = (used_new == '0);
		res_d.is_full     = (used_new == CAP);
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (accept) begin
			used_q <= used_new[CW-1:0];
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
